### hdl/eqh_pkg.sv
// ----------------------------------------------------------------------------
// eqh_pkg
// shared types, constants and elaboration-time cordic tables for the
// equatorial to horizontal coordinate converter
// ----------------------------------------------------------------------------
package eqh_pkg;

	localparam int FRAC_BITS_DEF     = 16;
	localparam int CORDIC_STAGES_DEF = 24;
	localparam int IQ                = 40;
	localparam int DW                = 64;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	typedef logic signed [DW-1:0] word_t;

	typedef struct packed {
		logic [20:0]        sidereal_time;
		logic [20:0]        right_ascension;
		logic signed [23:0] declination;
	} req_t;

	typedef struct packed {
		logic [24:0]        azimuth;
		logic signed [23:0] elevation;
	} rsp_t;

	// bitwise long division of a small top by d, n quotient bits
	function automatic logic [63:0] longdiv(input logic [63:0] top, input int n,
		input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = top;
		for (int i = 0; i < n; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// restoring division, constants only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic word_t mulq(input word_t a, input word_t b);
		logic         neg;
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] p;
		logic [63:0]  m;
		neg = a[63] ^ b[63];
		ua  = a[63] ? 64'(-a) : 64'(a);
		ub  = b[63] ? 64'(-b) : 64'(b);
		p   = {64'd0, ua} * {64'd0, ub};
		m   = {1'b0, p[IQ+62:IQ]};
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic word_t rad2deg_q();
		return $signed(longdiv(64'd180, 100, PI_Q60));
	endfunction

	// arctangent of 2^-i in degrees, q.40
	function automatic word_t atan_q(input int i);
		word_t acc;
		word_t term;
		int    e;
		acc = '0;
		if (i == 0) begin
			return 64'sd45 <<< IQ;
		end
		for (int k = 0; k < 64; k++) begin
			e = i * (2 * k + 1);
			if (e <= 60) begin
				term = $signed(udiv64(64'd1 << (60 - e), 64'(2 * k + 1)));
				acc  = k[0] ? acc - term : acc + term;
			end
		end
		return mulq((acc + (64'sd1 <<< 19)) >>> 20, rad2deg_q());
	endfunction

	function automatic word_t cordic_gain(input int n);
		word_t x;
		word_t y;
		word_t dx;
		word_t dy;
		x = 64'sd1 <<< IQ;
		y = '0;
		for (int i = 0; i < n; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (!y[63]) begin
				x = x + dx;
				y = y - dy;
			end else begin
				x = x - dx;
				y = y + dy;
			end
		end
		return x;
	endfunction

	function automatic word_t cordic_inv_gain(input int n);
		return $signed(longdiv(64'd1, 2 * IQ, 64'(cordic_gain(n))));
	endfunction

endpackage

### hdl/eqh_mul.sv
// ----------------------------------------------------------------------------
// eqh_mul
// two-stage signed q.40 multiplier from four 24x24 partial products
// ----------------------------------------------------------------------------
module eqh_mul (
	input  logic          clk,
	input  logic          en,
	input  eqh_pkg::word_t a,
	input  eqh_pkg::word_t b,
	output eqh_pkg::word_t p
);

	logic [63:0] ua;
	logic [63:0] ub;
	logic        neg_s1;
	logic [47:0] ll_s1;
	logic [47:0] lh_s1;
	logic [47:0] hl_s1;
	logic [47:0] hh_s1;
	logic [95:0] sum;
	logic [63:0] m;

	assign ua = a[63] ? 64'(-a) : 64'(a);
	assign ub = b[63] ? 64'(-b) : 64'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[63] ^ b[63];
			ll_s1  <= ua[23:0] * ub[23:0];
			lh_s1  <= ua[23:0] * ub[47:24];
			hl_s1  <= ua[47:24] * ub[23:0];
			hh_s1  <= ua[47:24] * ub[47:24];
		end
	end

	assign sum = {48'd0, ll_s1} + {24'd0, lh_s1, 24'd0} + {24'd0, hl_s1, 24'd0}
		+ {hh_s1, 48'd0};
	assign m   = {8'd0, sum[95:eqh_pkg::IQ]};

	always_ff @(posedge clk) begin
		if (en) begin
			p <= neg_s1 ? -$signed(m) : $signed(m);
		end
	end

endmodule

### hdl/eqh_rot.sv
// ----------------------------------------------------------------------------
// eqh_rot
// unrolled rotation-mode cordic, one stage per register, gives sine and cosine
// ----------------------------------------------------------------------------
module eqh_rot #(
	parameter int STAGES = eqh_pkg::CORDIC_STAGES_DEF,
	parameter int SBW    = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  eqh_pkg::word_t angle,
	input  logic [SBW-1:0] sb_in,
	output logic           out_vld,
	output eqh_pkg::word_t cos_val,
	output eqh_pkg::word_t sin_val,
	output logic [SBW-1:0] sb_out
);

	localparam eqh_pkg::word_t INV_GAIN = eqh_pkg::cordic_inv_gain(STAGES);

	eqh_pkg::word_t x_s  [1:STAGES];
	eqh_pkg::word_t y_s  [1:STAGES];
	eqh_pkg::word_t z_s  [1:STAGES];
	logic           v_s  [1:STAGES];
	logic [SBW-1:0] sb_s [1:STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam eqh_pkg::word_t TAB = eqh_pkg::atan_q(k);
		eqh_pkg::word_t xi;
		eqh_pkg::word_t yi;
		eqh_pkg::word_t zi;
		logic           vi;
		logic [SBW-1:0] sbi;

		if (k == 0) begin : g_first
			assign xi  = INV_GAIN;
			assign yi  = '0;
			assign zi  = angle;
			assign vi  = in_vld;
			assign sbi = sb_in;
		end else begin : g_next
			assign xi  = x_s[k];
			assign yi  = y_s[k];
			assign zi  = z_s[k];
			assign vi  = v_s[k];
			assign sbi = sb_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= sbi;
				if (!zi[63]) begin
					x_s[k+1] <= xi - (yi >>> k);
					y_s[k+1] <= yi + (xi >>> k);
					z_s[k+1] <= zi - TAB;
				end else begin
					x_s[k+1] <= xi + (yi >>> k);
					y_s[k+1] <= yi - (xi >>> k);
					z_s[k+1] <= zi + TAB;
				end
			end
		end
	end

	assign out_vld = v_s[STAGES];
	assign cos_val = x_s[STAGES];
	assign sin_val = y_s[STAGES];
	assign sb_out  = sb_s[STAGES];

endmodule

### hdl/eqh_vec.sv
// ----------------------------------------------------------------------------
// eqh_vec
// unrolled vectoring-mode cordic, gives magnitude and angle in degrees
// ----------------------------------------------------------------------------
module eqh_vec #(
	parameter int STAGES = eqh_pkg::CORDIC_STAGES_DEF,
	parameter int SBW    = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  eqh_pkg::word_t x_in,
	input  eqh_pkg::word_t y_in,
	input  logic [SBW-1:0] sb_in,
	output logic           out_vld,
	output eqh_pkg::word_t mag,
	output eqh_pkg::word_t ang,
	output logic [SBW-1:0] sb_out
);

	eqh_pkg::word_t x_s  [1:STAGES];
	eqh_pkg::word_t y_s  [1:STAGES];
	eqh_pkg::word_t z_s  [1:STAGES];
	logic           v_s  [1:STAGES];
	logic [SBW-1:0] sb_s [1:STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam eqh_pkg::word_t TAB = eqh_pkg::atan_q(k);
		eqh_pkg::word_t xi;
		eqh_pkg::word_t yi;
		eqh_pkg::word_t zi;
		logic           vi;
		logic [SBW-1:0] sbi;

		if (k == 0) begin : g_first
			assign xi  = x_in;
			assign yi  = y_in;
			assign zi  = '0;
			assign vi  = in_vld;
			assign sbi = sb_in;
		end else begin : g_next
			assign xi  = x_s[k];
			assign yi  = y_s[k];
			assign zi  = z_s[k];
			assign vi  = v_s[k];
			assign sbi = sb_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= sbi;
				if (!yi[63]) begin
					x_s[k+1] <= xi + (yi >>> k);
					y_s[k+1] <= yi - (xi >>> k);
					z_s[k+1] <= zi + TAB;
				end else begin
					x_s[k+1] <= xi - (yi >>> k);
					y_s[k+1] <= yi + (xi >>> k);
					z_s[k+1] <= zi - TAB;
				end
			end
		end
	end

	assign out_vld = v_s[STAGES];
	assign mag     = x_s[STAGES];
	assign ang     = z_s[STAGES];
	assign sb_out  = sb_s[STAGES];

endmodule

### hdl/equatorial_to_horizontal.sv
// ----------------------------------------------------------------------------
// equatorial_to_horizontal
// converts hour angle and declination at a configured site latitude into
// azimuth and elevation with pipelined cordic units
// ----------------------------------------------------------------------------
// usage:
//   requests (sidereal time, right ascension, declination) enter on req with
//   req_valid/req_ready; results (azimuth, elevation) leave on rsp with
//   rsp_valid/rsp_ready, one result per request, in order.
//   site latitude is written over the apb port at byte address 0; the user
//   must write it only while no request is in flight, which the block itself
//   does not enforce. reads return it.
//   three cordic pipelines run in series: sine/cosine, azimuth, elevation.
//   throughput is one request per cycle while rsp is not stalled.
//   reset clears all valid bits and the latitude register.
//   when rsp is stalled the whole pipeline holds and req_ready drops; no
//   request is lost or repeated.
// ----------------------------------------------------------------------------
module equatorial_to_horizontal #(
	parameter int CORDIC_STAGES = eqh_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          req_valid,
	output logic          req_ready,
	input  eqh_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output eqh_pkg::rsp_t rsp
);

	localparam int  FRAC_BITS          = eqh_pkg::FRAC_BITS_DEF;
	localparam int  SH                 = eqh_pkg::IQ - FRAC_BITS;
	// hour angle stays below two turns, latitude and declination below one
	localparam int  RED_STEPS          = 1;
	localparam logic IDX_SITE_LATITUDE = 1'b0;

	localparam logic signed [39:0] TWELVE    = 40'sd12 <<< FRAC_BITS;
	localparam logic signed [39:0] QUARTER   = 40'sd90 <<< FRAC_BITS;
	localparam logic signed [39:0] HALF_TURN = 40'sd180 <<< FRAC_BITS;
	localparam logic signed [39:0] FULL_TURN = 40'sd360 <<< FRAC_BITS;
	localparam logic [47:0]        FULL_W    = 48'd360 << FRAC_BITS;

	localparam eqh_pkg::word_t GAIN = eqh_pkg::cordic_gain(CORDIC_STAGES);
	localparam eqh_pkg::word_t D90  = 64'sd90 <<< eqh_pkg::IQ;
	localparam eqh_pkg::word_t D180 = 64'sd180 <<< eqh_pkg::IQ;
	localparam eqh_pkg::word_t D360 = 64'sd360 <<< eqh_pkg::IQ;
	localparam eqh_pkg::word_t RND  = 64'sd1 <<< (SH - 1);

	typedef struct packed {
		logic               neg;
		logic signed [39:0] ang;
	} fold_t;

	// reduce to one turn, then fold into -90..90 with a sign flip
	function automatic fold_t fold_angle(input logic signed [39:0] a);
		logic [47:0]        mag;
		logic signed [39:0] v;
		fold_t              r;
		mag = a[39] ? 48'(-a) : 48'(a);
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			if (mag >= (FULL_W << k)) begin
				mag = mag - (FULL_W << k);
			end
		end
		v = a[39] ? -$signed(mag[39:0]) : $signed(mag[39:0]);
		r.neg = 1'b0;
		if (v > HALF_TURN) begin
			v = v - FULL_TURN;
		end else if (v < -HALF_TURN) begin
			v = v + FULL_TURN;
		end
		if (v > QUARTER) begin
			v = v - HALF_TURN;
			r.neg = 1'b1;
		end else if (v < -QUARTER) begin
			v = v + HALF_TURN;
			r.neg = 1'b1;
		end
		r.ang = v;
		return r;
	endfunction

	// configuration
	logic signed [23:0] lat_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == IDX_SITE_LATITUDE)) begin
			lat_q <= pwdata[23:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == IDX_SITE_LATITUDE) begin
			prdata = {8'd0, lat_q};
		end
	end

	// global advance
	logic en;
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	// stage 0: hour angle
	logic signed [39:0] lst;
	logic signed [39:0] ra;
	logic signed [39:0] t;
	logic signed [39:0] h15;

	always_comb begin
		lst = {19'd0, req.sidereal_time};
		ra  = {19'd0, req.right_ascension};
		t   = lst - ra;
		if (t > TWELVE || t < -TWELVE) begin
			t = (lst > TWELVE) ? t - (TWELVE <<< 1) : t + (TWELVE <<< 1);
		end
		h15 = (t <<< 4) - t;
	end

	logic               vld_s0;
	logic signed [39:0] h15_s0;
	logic signed [23:0] dec_s0;
	logic               tneg_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h15_s0  <= h15;
			dec_s0  <= req.declination;
			tneg_s0 <= t[39];
		end
	end

	// stage 1: argument folding
	fold_t f_lat;
	fold_t f_dec;
	fold_t f_h;

	always_comb begin
		f_lat = fold_angle(40'(lat_q));
		f_dec = fold_angle(40'(dec_s0));
		f_h   = fold_angle(h15_s0);
	end

	logic           vld_s1;
	eqh_pkg::word_t lat_a_s1;
	eqh_pkg::word_t dec_a_s1;
	eqh_pkg::word_t h_a_s1;
	logic           lat_n_s1;
	logic           dec_n_s1;
	logic           h_n_s1;
	logic           tneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_a_s1 <= eqh_pkg::word_t'(f_lat.ang) <<< SH;
			dec_a_s1 <= eqh_pkg::word_t'(f_dec.ang) <<< SH;
			h_a_s1   <= eqh_pkg::word_t'(f_h.ang) <<< SH;
			lat_n_s1 <= f_lat.neg;
			dec_n_s1 <= f_dec.neg;
			h_n_s1   <= f_h.neg;
			tneg_s1  <= tneg_s0;
		end
	end

	// sine and cosine
	logic           rv_lat;
	logic           rv_dec;
	logic           rv_h;
	eqh_pkg::word_t c_lat;
	eqh_pkg::word_t s_lat;
	eqh_pkg::word_t c_dec;
	eqh_pkg::word_t s_dec;
	eqh_pkg::word_t c_h;
	eqh_pkg::word_t s_h;
	logic           n_lat;
	logic           n_dec;
	logic [1:0]     sb_h;

	eqh_rot #(.STAGES(CORDIC_STAGES), .SBW(1)) u_rot_lat (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .angle(lat_a_s1),
		.sb_in(lat_n_s1), .out_vld(rv_lat), .cos_val(c_lat), .sin_val(s_lat),
		.sb_out(n_lat)
	);

	eqh_rot #(.STAGES(CORDIC_STAGES), .SBW(1)) u_rot_dec (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .angle(dec_a_s1),
		.sb_in(dec_n_s1), .out_vld(rv_dec), .cos_val(c_dec), .sin_val(s_dec),
		.sb_out(n_dec)
	);

	eqh_rot #(.STAGES(CORDIC_STAGES), .SBW(2)) u_rot_h (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .angle(h_a_s1),
		.sb_in({h_n_s1, tneg_s1}), .out_vld(rv_h), .cos_val(c_h), .sin_val(s_h),
		.sb_out(sb_h)
	);

	// stage 2: apply half-turn sign
	logic           vld_s2;
	eqh_pkg::word_t sl_s2;
	eqh_pkg::word_t cl_s2;
	eqh_pkg::word_t sd_s2;
	eqh_pkg::word_t cd_s2;
	eqh_pkg::word_t sh_s2;
	eqh_pkg::word_t ch_s2;
	logic           tneg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= rv_h;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sl_s2   <= n_lat ? -s_lat : s_lat;
			cl_s2   <= n_lat ? -c_lat : c_lat;
			sd_s2   <= n_dec ? -s_dec : s_dec;
			cd_s2   <= n_dec ? -c_dec : c_dec;
			sh_s2   <= sb_h[1] ? -s_h : s_h;
			ch_s2   <= sb_h[1] ? -c_h : c_h;
			tneg_s2 <= sb_h[0];
		end
	end

	// stages 3-4: first products
	eqh_pkg::word_t p_ss;
	eqh_pkg::word_t p_cc;
	eqh_pkg::word_t p_sc;
	eqh_pkg::word_t p_cs;
	eqh_pkg::word_t p_ay;

	eqh_mul u_mul_ss (.clk(clk), .en(en), .a(sl_s2), .b(sd_s2), .p(p_ss));
	eqh_mul u_mul_cc (.clk(clk), .en(en), .a(cl_s2), .b(cd_s2), .p(p_cc));
	eqh_mul u_mul_sc (.clk(clk), .en(en), .a(sl_s2), .b(cd_s2), .p(p_sc));
	eqh_mul u_mul_cs (.clk(clk), .en(en), .a(cl_s2), .b(sd_s2), .p(p_cs));
	eqh_mul u_mul_ay (.clk(clk), .en(en), .a(cd_s2), .b(sh_s2), .p(p_ay));

	logic           vld_s3;
	logic           vld_s4;
	eqh_pkg::word_t ch_s3;
	eqh_pkg::word_t ch_s4;
	logic           tneg_s3;
	logic           tneg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s3   <= ch_s2;
			ch_s4   <= ch_s3;
			tneg_s3 <= tneg_s2;
			tneg_s4 <= tneg_s3;
		end
	end

	// stages 5-6: products with cos h
	eqh_pkg::word_t q_z;
	eqh_pkg::word_t q_x;

	eqh_mul u_mul_qz (.clk(clk), .en(en), .a(p_cc), .b(ch_s4), .p(q_z));
	eqh_mul u_mul_qx (.clk(clk), .en(en), .a(p_sc), .b(ch_s4), .p(q_x));

	logic           vld_s5;
	logic           vld_s6;
	eqh_pkg::word_t ss_s5;
	eqh_pkg::word_t ss_s6;
	eqh_pkg::word_t cs_s5;
	eqh_pkg::word_t cs_s6;
	eqh_pkg::word_t ay_s5;
	eqh_pkg::word_t ay_s6;
	logic           tneg_s5;
	logic           tneg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s5   <= p_ss;
			ss_s6   <= ss_s5;
			cs_s5   <= p_cs;
			cs_s6   <= cs_s5;
			ay_s5   <= p_ay;
			ay_s6   <= ay_s5;
			tneg_s5 <= tneg_s4;
			tneg_s6 <= tneg_s5;
		end
	end

	// stage 7: direction cosines
	logic           vld_s7;
	eqh_pkg::word_t zz_s7;
	eqh_pkg::word_t ax_s7;
	eqh_pkg::word_t ay_s7;
	logic           tneg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zz_s7   <= ss_s6 + q_z;
			ax_s7   <= q_x - cs_s6;
			ay_s7   <= ay_s6;
			tneg_s7 <= tneg_s6;
		end
	end

	// stages 8-9: gain-scaled z, azimuth vector set up
	eqh_pkg::word_t ey;

	eqh_mul u_mul_gain (.clk(clk), .en(en), .a(zz_s7), .b(GAIN), .p(ey));

	logic           vld_s8;
	logic           vld_s9;
	eqh_pkg::word_t vx_s8;
	eqh_pkg::word_t vx_s9;
	eqh_pkg::word_t vy_s8;
	eqh_pkg::word_t vy_s9;
	logic [5:0]     fl_s8;
	logic [5:0]     fl_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s8 <= ax_s7[63] ? -ax_s7 : ax_s7;
			vy_s8 <= ax_s7[63] ? -ay_s7 : ay_s7;
			fl_s8 <= {tneg_s7, ax_s7 == '0, !ay_s7[63] && ay_s7 != '0, ay_s7[63],
				!zz_s7[63] && zz_s7 != '0, zz_s7[63]};
			vx_s9 <= vx_s8;
			vy_s9 <= vy_s8;
			fl_s9 <= fl_s8;
		end
	end

	// azimuth vectoring
	logic           av_vld;
	eqh_pkg::word_t av_mag;
	eqh_pkg::word_t av_ang;
	logic [69:0]    av_sb;

	eqh_vec #(.STAGES(CORDIC_STAGES), .SBW(70)) u_vec_az (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s9), .x_in(vx_s9),
		.y_in(vy_s9), .sb_in({ey, fl_s9}), .out_vld(av_vld), .mag(av_mag),
		.ang(av_ang), .sb_out(av_sb)
	);

	// stage 10: azimuth special cases and quadrant
	eqh_pkg::word_t az_fix;

	always_comb begin
		az_fix = av_ang;
		if (av_sb[4]) begin
			az_fix = av_sb[3] ? D90 : (av_sb[2] ? -D90 : '0);
		end
		if (av_sb[5]) begin
			if (az_fix[63]) begin
				az_fix = az_fix + D180;
			end
		end else begin
			az_fix = az_fix[63] ? az_fix + D360 : az_fix + D180;
		end
	end

	logic           vld_s10;
	eqh_pkg::word_t az_s10;
	eqh_pkg::word_t vx_s10;
	eqh_pkg::word_t ey_s10;
	logic           vxz_s10;
	logic [1:0]     zs_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= av_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			az_s10  <= az_fix;
			vx_s10  <= av_mag;
			ey_s10  <= av_sb[69:6];
			vxz_s10 <= av_mag == '0;
			zs_s10  <= av_sb[1:0];
		end
	end

	// elevation vectoring
	logic           ev_vld;
	eqh_pkg::word_t ev_ang;
	logic [66:0]    ev_sb;

	eqh_vec #(.STAGES(CORDIC_STAGES), .SBW(67)) u_vec_el (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s10), .x_in(vx_s10),
		.y_in(ey_s10), .sb_in({az_s10, vxz_s10, zs_s10}), .out_vld(ev_vld), .mag(),
		.ang(ev_ang), .sb_out(ev_sb)
	);

	// output stage: clamp and round
	eqh_pkg::word_t el;
	eqh_pkg::word_t az;
	eqh_pkg::word_t el_r;
	eqh_pkg::word_t az_r;
	eqh_pkg::rsp_t  rsp_d;

	always_comb begin
		el = ev_ang;
		if (ev_sb[2]) begin
			el = ev_sb[1] ? D90 : (ev_sb[0] ? -D90 : '0);
		end
		if (el > D90) begin
			el = D90;
		end
		if (el < -D90) begin
			el = -D90;
		end
		az = ev_sb[66:3];
		if (az[63]) begin
			az = '0;
		end
		if (az > D360) begin
			az = D360;
		end
		az_r            = (az + RND) >>> SH;
		el_r            = (el + RND) >>> SH;
		rsp_d.azimuth   = az_r[24:0];
		rsp_d.elevation = el_r[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= ev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp <= rsp_d;
		end
	end

	// checks
	a_rot_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_lat == rv_h) && (rv_dec == rv_h))
		else $error("sine/cosine units out of step");

	a_mag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 |-> !vx_s10[63])
		else $error("horizontal magnitude negative");

	a_az_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 |-> !az_s10[63])
		else $error("azimuth negative after quadrant fix");

endmodule
